// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gaod_pkg.sv =====
// ----------------------------------------------------------------------------
// gaod_pkg: shared types and constants
// Transaction structs, request codes and sizes of the grid box store.
// ----------------------------------------------------------------------------
package gaod_pkg;

  localparam int MAX_ENTRIES  = 256;
  localparam int GRID_COLUMNS = 16;
  localparam int GRID_ROWS    = 16;
  localparam int CELL_COUNT   = GRID_COLUMNS * GRID_ROWS;
  localparam int ENTRY_W      = $clog2(MAX_ENTRIES);
  localparam int CELL_W       = $clog2(CELL_COUNT + 1);
  localparam int COL_W        = $clog2(GRID_COLUMNS);
  localparam int ROW_W        = $clog2(GRID_ROWS);

  localparam logic [1:0] REQ_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] REQ_LOAD_CELL  = 2'd1;
  localparam logic [1:0] REQ_AREA       = 2'd2;
  localparam logic [1:0] REQ_SINGLE     = 2'd3;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_BREAKABLE = 2'd2;

  localparam logic [1:0] CFG_MIN_X   = 2'd0;
  localparam logic [1:0] CFG_MIN_Y   = 2'd1;
  localparam logic [1:0] CFG_WSHIFT  = 2'd2;
  localparam logic [1:0] CFG_DSHIFT  = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         entry_index;
    logic [8:0]         cell_index;
    logic [8:0]         cell_start;
    logic [1:0]         obstacle_kind;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_max_y;
    logic [15:0]        hit_points;
    logic [63:0]        tick;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [8:0] damaged_count;
  } out_item_t;

  // Cell rectangle handed from the cell mapper to the sequencer.
  typedef struct packed {
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
  } cell_rect_t;

  // Floor shift of a coordinate relative to the origin, clamped to the grid.
  function automatic logic [6:0] axis_bin(input logic signed [15:0] coord,
                                          input logic signed [15:0] origin,
                                          input logic [3:0] shift,
                                          input logic [6:0] last);
    logic [16:0] diff;
    logic [16:0] v;
    diff = 17'(coord) - 17'(origin);
    v = diff >> shift;
    if (coord <= origin) return 7'd0;
    if (v > 17'(last)) return last;
    return v[6:0];
  endfunction

endpackage

// ===== sv/grid_aabb_overlap_damage.sv =====
// ----------------------------------------------------------------------------
// grid_aabb_overlap_damage: grid indexed box store with damage requests
// Loads, area damage walk and single damage over one shared entry port.
// ----------------------------------------------------------------------------
// The block is not ready while a transaction is in progress. A load passes
// through S_RDONE and a single damage through S_RDONE and S_SCHK. An area
// request reads the bounds of each cell of the clamped rectangle and then
// each entry in the cell in turn; the walk is set by the single read port of
// the entry memory, which serves one entry at a time. No clearing pass is
// needed after reset.
module grid_aabb_overlap_damage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gaod_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gaod_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import gaod_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CELLB = 9'b000000010,
    S_CELLE = 9'b000000100,
    S_RDENT = 9'b000001000,
    S_CHECK = 9'b000010000,
    S_NEXTC = 9'b000100000,
    S_RDONE = 9'b001000000,
    S_SCHK  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] min_x_r, min_y_r;
  logic [3:0] wshift_r, dshift_r;

  in_item_t item_r;
  cell_rect_t rect;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [CELL_W-1:0] ent_r;
  logic [8:0] count_r;
  logic acc_r;

  // Entry memories (payload) and flag bits (reset).
  logic [63:0] bounds_mem [MAX_ENTRIES];
  logic [15:0] hp_mem [MAX_ENTRIES];
  logic [63:0] btick_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] intact_r;
  logic [MAX_ENTRIES-1:0] brk_r;
  logic [CELL_W-1:0] cell_mem [CELL_COUNT+1];
  logic [CELL_COUNT:0] cvalid_r;

  logic [63:0] bb_r;
  logic [15:0] hp_rd_r;
  logic [CELL_W-1:0] cell_rd_r;

  logic [ENTRY_W-1:0] rd_addr;
  logic [CELL_W-1:0] cell_addr;
  logic [CELL_W+1:0] cell_lin;
  logic hit;
  logic brk_now;

  gaod_cell_map u_map (
    .room_min_x(min_x_r), .room_min_y(min_y_r),
    .wshift(wshift_r), .dshift(dshift_r), .item(item_r), .rect(rect)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      min_y_r <= '0;
      wshift_r <= 4'd8;
      dshift_r <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_X:  min_x_r <= cfg_data;
        CFG_MIN_Y:  min_y_r <= cfg_data;
        CFG_WSHIFT: wshift_r <= cfg_data[3:0];
        CFG_DSHIFT: dshift_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.accepted = acc_r;
  assign out_data.damaged_count = count_r;

  always_comb begin
    cell_lin = (CELL_W+2)'(row_r) * (CELL_W+2)'(GRID_COLUMNS) + (CELL_W+2)'(col_r);
    if (state_r == S_CELLB) cell_addr = cell_lin[CELL_W-1:0];
    else cell_addr = cell_lin[CELL_W-1:0] + CELL_W'(1);
    if (state_r == S_RDENT) rd_addr = ent_r[ENTRY_W-1:0];
    else rd_addr = item_r.entry_index;
  end

  always_ff @(posedge clk) begin
    bb_r <= bounds_mem[rd_addr];
    hp_rd_r <= hp_mem[rd_addr];
    cell_rd_r <= cvalid_r[cell_addr] ? cell_mem[cell_addr] : '0;
  end

  always_comb begin
    hit = intact_r[ent_r[ENTRY_W-1:0]] && brk_r[ent_r[ENTRY_W-1:0]] &&
          !($signed(bb_r[15:0]) > item_r.box_max_x) &&
          !($signed(bb_r[47:32]) < item_r.box_min_x) &&
          !($signed(bb_r[31:16]) > item_r.box_max_y) &&
          !($signed(bb_r[63:48]) < item_r.box_min_y) &&
          (hp_rd_r != 16'd0);
    brk_now = (state_r == S_CHECK) && hit;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RDONE && item_r.req_type == REQ_LOAD_ENTRY) begin
      bounds_mem[item_r.entry_index] <= {item_r.box_max_y, item_r.box_max_x,
                                         item_r.box_min_y, item_r.box_min_x};
      hp_mem[item_r.entry_index] <= (item_r.obstacle_kind == KIND_BREAKABLE) ?
                                    item_r.hit_points : 16'd0;
    end
    if (state_r == S_RDONE && item_r.req_type == REQ_LOAD_CELL &&
        item_r.cell_index <= 9'(CELL_COUNT))
      cell_mem[item_r.cell_index] <= item_r.cell_start;
    if (brk_now) begin
      hp_mem[ent_r[ENTRY_W-1:0]] <= '0;
      btick_mem[ent_r[ENTRY_W-1:0]] <= item_r.tick;
    end
    if (state_r == S_SCHK && acc_r) begin
      if (item_r.hit_points < hp_rd_r)
        hp_mem[item_r.entry_index] <= hp_rd_r - item_r.hit_points;
      else begin
        hp_mem[item_r.entry_index] <= '0;
        btick_mem[item_r.entry_index] <= item_r.tick;
      end
    end
  end

  // While the entries of a cell are walked, the cell read port keeps
  // returning the start of the next cell, which is the end of the walk.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (in_data.req_type == REQ_AREA) ? S_NEXTC :
                                         S_RDONE;
      S_NEXTC: state_nxt = (rect.r1 < rect.r0 || rect.c1 < rect.c0) ? S_OUT : S_CELLB;
      S_CELLB: state_nxt = S_CELLE;
      S_CELLE: state_nxt = S_RDENT;
      S_RDENT: state_nxt = (ent_r < cell_rd_r && ent_r < CELL_W'(MAX_ENTRIES)) ?
                           S_CHECK : S_RDONE;
      S_CHECK: state_nxt = S_RDENT;
      S_RDONE: begin
        if (item_r.req_type == REQ_AREA)
          state_nxt = (col_r == rect.c1 && row_r == rect.r1) ? S_OUT : S_CELLB;
        else if (item_r.req_type == REQ_SINGLE) state_nxt = S_SCHK;
        else state_nxt = S_OUT;
      end
      S_SCHK:  state_nxt = S_OUT;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // S_RDENT doubles as the read-issue cycle; S_CHECK evaluates the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      intact_r <= '0;
      brk_r    <= '0;
      cvalid_r <= '0;
      acc_r    <= 1'b0;
      count_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          item_r  <= in_data;
          count_r <= '0;
        end
        S_NEXTC: begin
          col_r <= rect.c0;
          row_r <= rect.r0;
          acc_r <= 1'b1;
        end
        S_CELLB: ;
        S_CELLE: ent_r <= cell_rd_r;
        S_RDENT: ;
        S_CHECK: begin
          ent_r <= ent_r + CELL_W'(1);
          if (hit) begin
            intact_r[ent_r[ENTRY_W-1:0]] <= 1'b0;
            if (count_r != 9'd511) count_r <= count_r + 9'd1;
          end
        end
        S_RDONE: begin
          if (item_r.req_type == REQ_AREA) begin
            if (col_r == rect.c1) begin
              col_r <= rect.c0;
              row_r <= row_r + ROW_W'(1);
            end else col_r <= col_r + COL_W'(1);
          end else if (item_r.req_type == REQ_LOAD_ENTRY) begin
            acc_r <= 1'b1;
            if (item_r.obstacle_kind > KIND_BREAKABLE) begin
              intact_r[item_r.entry_index] <= 1'b0;
              brk_r[item_r.entry_index] <= 1'b0;
            end else begin
              intact_r[item_r.entry_index] <= item_r.obstacle_kind != KIND_NONE;
              brk_r[item_r.entry_index] <= item_r.obstacle_kind == KIND_BREAKABLE;
            end
          end else if (item_r.req_type == REQ_LOAD_CELL) begin
            acc_r <= item_r.cell_index <= 9'(CELL_COUNT);
            if (item_r.cell_index <= 9'(CELL_COUNT))
              cvalid_r[item_r.cell_index] <= 1'b1;
          end else begin
            acc_r <= intact_r[item_r.entry_index] && brk_r[item_r.entry_index] &&
                     item_r.hit_points != 16'd0;
          end
        end
        S_SCHK: if (acc_r && !(item_r.hit_points < hp_rd_r))
          intact_r[item_r.entry_index] <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/gaod_cell_map.sv =====
// ----------------------------------------------------------------------------
// gaod_cell_map: query box to cell rectangle
// Maps the query corners to clamped grid columns and rows.
// ----------------------------------------------------------------------------
module gaod_cell_map (
  input  logic signed [15:0]   room_min_x,
  input  logic signed [15:0]   room_min_y,
  input  logic [3:0]           wshift,
  input  logic [3:0]           dshift,
  input  gaod_pkg::in_item_t   item,
  output gaod_pkg::cell_rect_t rect
);
  import gaod_pkg::*;

  logic [6:0] c0, c1, r0, r1;

  always_comb begin
    c0 = axis_bin(item.box_min_x, room_min_x, wshift, 7'(GRID_COLUMNS - 1));
    c1 = axis_bin(item.box_max_x, room_min_x, wshift, 7'(GRID_COLUMNS - 1));
    r0 = axis_bin(item.box_min_y, room_min_y, dshift, 7'(GRID_ROWS - 1));
    r1 = axis_bin(item.box_max_y, room_min_y, dshift, 7'(GRID_ROWS - 1));
    rect.c0 = c0[COL_W-1:0];
    rect.c1 = c1[COL_W-1:0];
    rect.r0 = r0[ROW_W-1:0];
    rect.r1 = r1[ROW_W-1:0];
  end

endmodule

// ===== sv/gaod_checker.sv =====
// ----------------------------------------------------------------------------
// gaod_checker: port level checks
// Checks the handshake and result rules seen at the top level ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gaod_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gaod_pkg::out_item_t out_data
);
  import gaod_pkg::*;

  // A transaction is not taken while a result is pending.
  `CHK_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken with result pending")
  // Ready falls after an input transaction.
  `CHK_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready held after accept")
  // A refused request never reports breaks.
  `CHK_IMPLY(a_cnt, clk, rst_n, out_valid && !out_data.accepted,
             out_data.damaged_count == 9'd0, "count on refused request")
  // A pending result holds.
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data),
            "result dropped or changed")

endmodule

bind grid_aabb_overlap_damage gaod_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
